// ----- src/sha256_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and round functions for the sha-256 stream hasher
// no dependencies; used by sha256_ctrl, sha256_datapath and sha256_stream_hasher

package sha256_pkg;

    // input item codes
    localparam logic [1:0] MODE_ABSORB     = 2'd0;
    localparam logic [1:0] MODE_ABSORB_FIN = 2'd1;
    localparam logic [1:0] MODE_FINISH     = 2'd2;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_FILL,
        ST_LEN,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      shift_en;
        byte_sel_t byte_sel;
        logic [2:0] len_sel;
        logic      count_len;
        logic      round_en;
        logic [5:0] round_idx;
        logic      fold_en;
        logic      restart;
        logic      out_load;
        logic [2:0] word_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        case (idx)
            3'd0:    init_h = 32'h6a09e667;
            3'd1:    init_h = 32'hbb67ae85;
            3'd2:    init_h = 32'h3c6ef372;
            3'd3:    init_h = 32'ha54ff53a;
            3'd4:    init_h = 32'h510e527f;
            3'd5:    init_h = 32'h9b05688c;
            3'd6:    init_h = 32'h1f83d9ab;
            default: init_h = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

// ----- src/sha256_ctrl.sv -----
`timescale 1ns / 1ps
// control state machine: byte counting, padding sequence, round and digest counters
// depends on sha256_pkg

module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  in_item_t item,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t     state_reg, state_next;
    state_t     resume_reg, resume_next;
    state_t     after_state;
    logic [5:0] fill_reg, fill_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] word_reg, word_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            resume_reg <= ST_IDLE;
            fill_reg   <= '0;
            rnd_reg    <= '0;
            word_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            fill_reg   <= fill_next;
            rnd_reg    <= rnd_next;
            word_reg   <= word_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        resume_next   = resume_reg;
        fill_next     = fill_reg;
        rnd_next      = rnd_reg;
        word_next     = word_reg;
        after_state   = ST_IDLE;
        item_ready    = 1'b0;
        cmd           = '0;
        cmd.len_sel   = fill_reg[2:0];
        cmd.round_idx = rnd_reg;
        cmd.word_idx  = word_reg;

        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    case (item.mode)
                        MODE_ABSORB, MODE_ABSORB_FIN:
                        begin
                            cmd.shift_en  = 1'b1;
                            cmd.byte_sel  = SEL_DATA;
                            cmd.count_len = 1'b1;
                            fill_next     = fill_reg + 6'd1;
                            after_state   = (item.mode == MODE_ABSORB_FIN) ? ST_PAD : ST_IDLE;
                            // a full block is compressed before going on
                            if (fill_reg == BLOCK_LAST)
                            begin
                                state_next  = ST_ROUND;
                                resume_next = after_state;
                            end
                            else
                            begin
                                state_next = after_state;
                            end
                        end
                        MODE_FINISH:
                        begin
                            state_next = ST_PAD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PAD:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = SEL_PAD;
                fill_next    = fill_reg + 6'd1;
                if (fill_reg == BLOCK_LAST)
                begin
                    state_next  = ST_ROUND;
                    resume_next = ST_FILL;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (fill_reg == LEN_POS)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    cmd.shift_en = 1'b1;
                    cmd.byte_sel = SEL_ZERO;
                    fill_next    = fill_reg + 6'd1;
                    if (fill_reg == BLOCK_LAST)
                    begin
                        state_next  = ST_ROUND;
                        resume_next = ST_FILL;
                    end
                end
            end
            ST_LEN:
            begin
                // length bytes occupy the last eight slots, msb first
                cmd.shift_en = 1'b1;
                cmd.byte_sel = SEL_LEN;
                fill_next    = fill_reg + 6'd1;
                if (fill_reg == BLOCK_LAST)
                begin
                    state_next  = ST_ROUND;
                    resume_next = ST_OUT;
                end
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == ROUND_LAST)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold_en = 1'b1;
                state_next  = resume_reg;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    word_next    = word_reg + 3'd1;
                    if (word_reg == WORD_LAST)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/sha256_datapath.sv -----
`timescale 1ns / 1ps
// datapath: 16-word block window doubling as message schedule, round unit,
// hash words, bit length counter and digest output register; depends on sha256_pkg

module sha256_datapath
    import sha256_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  logic [7:0] data_byte,
    input  logic       result_ready,
    output dp_stat_t   stat,
    output logic       result_valid,
    output out_item_t  result
);

    logic [31:0] win_reg [16];
    logic [31:0] v_reg   [8];
    logic [31:0] h_reg   [8];
    logic [63:0] len_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;

    logic [7:0]  shift_byte;
    logic [31:0] w_new;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb
    begin
        case (cmd.byte_sel)
            SEL_DATA: shift_byte = data_byte;
            SEL_PAD:  shift_byte = PAD_BYTE;
            SEL_LEN:  shift_byte = len_reg[{~cmd.len_sel, 3'b000} +: 8];
            default:  shift_byte = 8'h00;
        endcase
    end

    // win_reg[0] is w[t]; the window slides one word per round
    assign w_new = small_sigma1(win_reg[14]) + win_reg[9] + small_sigma0(win_reg[1])
                 + win_reg[0];
    assign ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1    = v_reg[7] + big_sigma1(v_reg[4]) + ch + round_k(cmd.round_idx) + win_reg[0];
    assign t2    = big_sigma0(v_reg[0]) + maj;

    always_ff @(posedge clk)
    begin
        if (cmd.shift_en)
        begin
            // bytes enter at the bottom and move up, first byte ends in word 0 msb
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_reg[15] <= {win_reg[15][23:0], shift_byte};
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else
        begin
            // working variables track the hash words outside the rounds
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_h(3'(i));
            end
            len_reg <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= init_h(3'(i));
                end
            end
            else if (cmd.fold_en)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end

            if (cmd.restart)
            begin
                len_reg <= '0;
            end
            else if (cmd.count_len)
            begin
                len_reg <= len_reg + 64'd8;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_item_reg.digest_word <= h_reg[cmd.word_idx];
            out_item_reg.word_index  <= cmd.word_idx;
            out_item_reg.last_word   <= (cmd.word_idx == WORD_LAST);
        end
    end

    assign stat.out_free = !out_valid_reg || result_ready;
    assign result_valid  = out_valid_reg;
    assign result        = out_item_reg;

endmodule

// ----- src/sha256_stream_hasher.sv -----
`timescale 1ns / 1ps
// an absorbed byte is shifted into the block window; a byte that completes a block holds off
// further input through 64 rounds on one shared round unit and a fold into the hash words
// finalize pads one byte per cycle, pausing to compress any full block, up to the block
// end, compresses, then shows the eight digest words one per cycle as they are taken
// reset (rst_n, async, active low): initial hash values, empty length, no pending output
// depends on sha256_pkg, sha256_ctrl and sha256_datapath

module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sha256_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .stat       (stat),
        .cmd        (cmd)
    );

    sha256_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_byte    (item.data_byte),
        .result_ready (result_ready),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
